// ----- rtl/bse_pkg.sv -----
// ----------------------------------------------------------------------------
// bse_pkg
// Shared types and codes for the byte string escaper.
// ----------------------------------------------------------------------------
package bse_pkg;

  // Request type codes
  localparam logic [1:0] REQ_OPEN  = 2'd0;
  localparam logic [1:0] REQ_DATA  = 2'd1;
  localparam logic [1:0] REQ_CLOSE = 2'd2;

  // Quote mode codes
  localparam logic [1:0] QUOTE_OFF    = 2'd0;
  localparam logic [1:0] QUOTE_SINGLE = 2'd1;
  localparam logic [1:0] QUOTE_DOUBLE = 2'd2;

  // Configuration register indexes
  localparam logic CFG_QUOTE_MODE = 1'b0;
  localparam logic CFG_HEX_UPPER  = 1'b1;

  // Characters
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DEL    = 8'h7F;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_X  = 8'h78;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_LOW_A  = 8'h61;

  // Input beat
  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] data_byte;
  } req_t;

  // Output beat
  typedef struct packed {
    logic [7:0] out_char;
    logic       run_last;
  } res_t;

  // Classified job: up to four characters, index of the last one
  typedef struct packed {
    logic [3:0][7:0] chars;
    logic [1:0]      last_idx;
  } job_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ----- rtl/bse_front.sv -----
// ----------------------------------------------------------------------------
// bse_front
// Accepts input beats and expands each into a job of escaped characters.
// ----------------------------------------------------------------------------
module bse_front (
  input  logic               in_valid,
  output logic               in_stall,
  input  bse_pkg::req_t      in_data,
  input  logic [1:0]         quote_mode,
  input  logic               hex_upper,
  input  bse_pkg::q_status_t q_status,
  output logic               push,
  output bse_pkg::job_t      job
);

  logic [7:0] quote_ch;
  logic       has_out;
  logic [7:0] c;

  function automatic logic [7:0] hex_digit(input logic [3:0] v, input logic upper);
    logic [7:0] base;
    base = upper ? bse_pkg::CH_UP_A : bse_pkg::CH_LOW_A;
    if (v < 4'd10) return bse_pkg::CH_ZERO + {4'd0, v};
    return base + {4'd0, v - 4'd10};
  endfunction

  assign c = in_data.data_byte;

  // Active quote character, zero when quoting is off
  always_comb begin
    unique case (quote_mode)
      bse_pkg::QUOTE_SINGLE: quote_ch = bse_pkg::CH_SQUOTE;
      bse_pkg::QUOTE_DOUBLE: quote_ch = bse_pkg::CH_DQUOTE;
      default:               quote_ch = 8'd0;
    endcase
  end

  // Classify the beat
  always_comb begin
    job.chars    = '0;
    job.last_idx = 2'd0;
    has_out      = 1'b0;
    unique case (in_data.req_type)
      bse_pkg::REQ_OPEN, bse_pkg::REQ_CLOSE: begin
        job.chars[0] = quote_ch;
        has_out      = (quote_ch != 8'd0);
      end
      bse_pkg::REQ_DATA: begin
        has_out      = 1'b1;
        job.chars[0] = bse_pkg::CH_BSLASH;
        job.last_idx = 2'd1;
        priority if (c == bse_pkg::CH_NL) begin
          job.chars[1] = bse_pkg::CH_LOW_N;
        end else if (c == bse_pkg::CH_CR) begin
          job.chars[1] = bse_pkg::CH_LOW_R;
        end else if (c == bse_pkg::CH_TAB) begin
          job.chars[1] = bse_pkg::CH_LOW_T;
        end else if (c == bse_pkg::CH_BSLASH) begin
          job.chars[1] = bse_pkg::CH_BSLASH;
        end else if (quote_ch != 8'd0 && c == quote_ch) begin
          job.chars[1] = quote_ch;
        end else if (c < bse_pkg::CH_SPACE || c >= bse_pkg::CH_DEL) begin
          job.chars[1] = bse_pkg::CH_LOW_X;
          job.chars[2] = hex_digit(c[7:4], hex_upper);
          job.chars[3] = hex_digit(c[3:0], hex_upper);
          job.last_idx = 2'd3;
        end else begin
          job.chars[0] = c;
          job.last_idx = 2'd0;
        end
      end
      default: has_out = 1'b0;
    endcase
  end

  // Hold off while the queue is full; empty jobs are dropped
  assign in_stall = q_status.full;
  assign push     = in_valid && !q_status.full && has_out;

endmodule

// ----- rtl/bse_queue.sv -----
// ----------------------------------------------------------------------------
// bse_queue
// Small job FIFO between the front and the back.
// ----------------------------------------------------------------------------
module bse_queue #(
  parameter int DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  bse_pkg::job_t      push_job,
  input  logic               pop,
  output bse_pkg::job_t      head_job,
  output bse_pkg::q_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);

  bse_pkg::job_t    entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_MAX) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR_MAX) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_job;
  end

  assign head_job     = entries[rd_ptr];
  assign status.full  = (count == CNT_MAX);
  assign status.empty = (count == '0);

endmodule

// ----- rtl/bse_back.sv -----
// ----------------------------------------------------------------------------
// bse_back
// Pulls jobs from the queue and sends their characters one beat at a time.
// ----------------------------------------------------------------------------
module bse_back (
  input  logic               clk,
  input  logic               rst,
  input  bse_pkg::job_t      head_job,
  input  bse_pkg::q_status_t q_status,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output bse_pkg::res_t      out_data
);

  bse_pkg::job_t cur;
  logic          busy;
  logic [1:0]    idx;
  logic          adv;
  logic          emit;
  logic          done;

  // Output register may advance when empty or taken
  assign adv  = !out_valid || !out_stall;
  assign emit = busy && adv;
  assign done = emit && (idx == cur.last_idx);
  assign pop  = !q_status.empty && (!busy || done);

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      idx       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (adv) out_valid <= busy;
      if (pop) begin
        busy <= 1'b1;
        idx  <= 2'd0;
      end else if (done) begin
        busy <= 1'b0;
      end else if (emit) begin
        idx <= idx + 2'd1;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (pop) cur <= head_job;
    if (emit) begin
      out_data.out_char <= cur.chars[idx];
      out_data.run_last <= (idx == cur.last_idx);
    end
  end

endmodule

// ----- rtl/byte_string_escaper_top.sv -----
// ----------------------------------------------------------------------------
// byte_string_escaper_top
// C-style string escaper: turns open, data and close requests into a stream
// of printable escaped characters.
//
// Input channel (in_valid/in_stall/in_data) carries one request per beat:
// open, data byte or close. Output channel (out_valid/out_stall/out_data)
// carries one character per beat; run_last marks the final character of a
// request. Open/close with quoting off, and unused request codes, produce
// no beats. The cfg port writes quote mode and hex case; write it only when
// the block is idle.
// The first character of a request passes through the job queue, the back
// end's job register and the output register. One output character per cycle
// while out_stall is low; a request expands to 1 to 4 characters (4 for a
// hex escape). The single output character port sets this rate, and the job
// queue lets input be accepted while the output side is busy or stalled.
// Reset clears the queue, the output register and the configuration.
// A stalled output holds its beat; once the queue fills, in_stall rises.
// ----------------------------------------------------------------------------
module byte_string_escaper_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  bse_pkg::req_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output bse_pkg::res_t  out_data,
  input  logic           cfg_we,
  input  logic           cfg_index,
  input  logic [1:0]     cfg_data
);

  logic [1:0]         quote_mode;
  logic               hex_upper;
  logic               push;
  logic               pop;
  bse_pkg::job_t      push_job;
  bse_pkg::job_t      head_job;
  bse_pkg::q_status_t q_status;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      quote_mode <= bse_pkg::QUOTE_OFF;
      hex_upper  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bse_pkg::CFG_QUOTE_MODE: quote_mode <= cfg_data;
        bse_pkg::CFG_HEX_UPPER:  hex_upper  <= cfg_data[0];
        default:                 hex_upper  <= hex_upper;
      endcase
    end
  end

  bse_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .quote_mode (quote_mode),
    .hex_upper  (hex_upper),
    .q_status   (q_status),
    .push       (push),
    .job        (push_job)
  );

  bse_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .status   (q_status)
  );

  bse_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_job  (head_job),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- tb/byte_string_escaper_top_tb.sv -----
// ----------------------------------------------------------------------------
// byte_string_escaper_top_tb
// Self-checking bench for the string escaper. A clocked driver feeds request
// beats from a queue, and a scoreboard in the predictor expands each accepted
// request into the characters the block must emit. A clocked monitor checks
// every output beat in order. Both sides insert random idle cycles. The run
// steps through every quote mode and hex case, including the unused quote
// code, with directed corner bytes first and then random strings.
// ----------------------------------------------------------------------------
module byte_string_escaper_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Codes the package leaves unnamed
  localparam logic [1:0] QUOTE_SPARE = 2'd3;
  localparam logic [1:0] REQ_SPARE   = 2'd3;

  localparam int SETTLE_CYCLES = 8;     // outlasts the request-to-output path plus queue slack
  localparam int QUIET_LIMIT   = 2000;  // cycles with no traffic before giving up
  localparam int PHASES        = 6;

  logic            clk       = 1'b0;
  logic            rst       = 1'b1;
  logic            in_valid  = 1'b0;
  logic            in_stall;
  bse_pkg::req_t   in_data   = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  bse_pkg::res_t   out_data;
  logic            cfg_we    = 1'b0;
  logic            cfg_index = bse_pkg::CFG_QUOTE_MODE;
  logic [1:0]      cfg_data  = '0;

  // Bench copy of the configuration
  logic [1:0] quote_sel = bse_pkg::QUOTE_OFF;
  logic       hex_caps  = 1'b0;

  bse_pkg::req_t req_fifo[$];      // request beats not yet driven
  bse_pkg::res_t escaped_fifo[$];  // characters the block still owes
  bit   steady     = 1'b0;
  int   err_count  = 0;
  int   in_gap     = 0;
  int   stall_left = 0;
  int   quiet_cycles = 0;

  logic [7:0] corner_bytes [14] = '{8'h00, bse_pkg::CH_NL, bse_pkg::CH_CR,
                                    bse_pkg::CH_TAB, bse_pkg::CH_BSLASH,
                                    bse_pkg::CH_DQUOTE, bse_pkg::CH_SQUOTE, 8'h1F,
                                    bse_pkg::CH_SPACE, 8'h7E, bse_pkg::CH_DEL, 8'h80,
                                    8'hAB, 8'hFF};

  logic [1:0] quote_plan [PHASES] = '{bse_pkg::QUOTE_SINGLE, QUOTE_SPARE, QUOTE_SPARE,
                                      bse_pkg::QUOTE_DOUBLE, bse_pkg::QUOTE_SINGLE,
                                      bse_pkg::QUOTE_OFF};
  logic [1:0] caps_plan  [PHASES] = '{2'd0, 2'd1, 2'd3, 2'd2, 2'd1, 2'd0};

  byte_string_escaper_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int idle_draw();
    return steady ? 0 : $urandom_range(0, 4);
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] nib);
    if (nib < 4'd10) return bse_pkg::CH_ZERO + {4'h0, nib};
    return (hex_caps ? bse_pkg::CH_UP_A : bse_pkg::CH_LOW_A) + {4'h0, nib - 4'd10};
  endfunction

  // Expand one accepted request into the characters it should produce
  function automatic void escape_request(bse_pkg::req_t r);
    logic [7:0]    q;
    logic [7:0]    c;
    logic [7:0]    seq[$];
    bse_pkg::res_t beat;
    q = (quote_sel == bse_pkg::QUOTE_SINGLE) ? bse_pkg::CH_SQUOTE :
        (quote_sel == bse_pkg::QUOTE_DOUBLE) ? bse_pkg::CH_DQUOTE : 8'h00;
    c = r.data_byte;
    case (r.req_type)
      bse_pkg::REQ_OPEN, bse_pkg::REQ_CLOSE: begin
        if (q != 8'h00) seq.push_back(q);
      end
      bse_pkg::REQ_DATA: begin
        // control escapes and backslash win over the quote test
        if (c == bse_pkg::CH_NL) begin
          seq.push_back(bse_pkg::CH_BSLASH);
          seq.push_back(bse_pkg::CH_LOW_N);
        end else if (c == bse_pkg::CH_CR) begin
          seq.push_back(bse_pkg::CH_BSLASH);
          seq.push_back(bse_pkg::CH_LOW_R);
        end else if (c == bse_pkg::CH_TAB) begin
          seq.push_back(bse_pkg::CH_BSLASH);
          seq.push_back(bse_pkg::CH_LOW_T);
        end else if (c == bse_pkg::CH_BSLASH) begin
          seq.push_back(bse_pkg::CH_BSLASH);
          seq.push_back(bse_pkg::CH_BSLASH);
        end else if (q != 8'h00 && c == q) begin
          seq.push_back(bse_pkg::CH_BSLASH);
          seq.push_back(q);
        end else if (c < bse_pkg::CH_SPACE || c >= bse_pkg::CH_DEL) begin
          seq.push_back(bse_pkg::CH_BSLASH);
          seq.push_back(bse_pkg::CH_LOW_X);
          seq.push_back(hex_char(c[7:4]));
          seq.push_back(hex_char(c[3:0]));
        end else begin
          seq.push_back(c);
        end
      end
      default: ;  // spare request code: no output
    endcase
    foreach (seq[i]) begin
      beat.out_char = seq[i];
      beat.run_last = (i == seq.size() - 1);
      escaped_fifo.push_back(beat);
    end
  endfunction

  // Request driver: holds a stalled beat, otherwise waits out its gap
  always @(posedge clk) begin : feed_requests
    int g;
    if (rst) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) escape_request(in_data);
      g = in_valid ? idle_draw() : in_gap;
      if (g != 0) begin
        in_valid <= 1'b0;
        in_gap   <= g - 1;
      end else if (req_fifo.size() != 0) begin
        in_data  <= req_fifo.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output monitor: check each beat, then stall for a random stretch
  always @(posedge clk) begin : check_chars
    bse_pkg::res_t want;
    int            n;
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      if (escaped_fifo.size() == 0) begin
        $display("%0t: unexpected beat, char %h last %b", $time,
                 out_data.out_char, out_data.run_last);
        err_count++;
      end else begin
        want = escaped_fifo.pop_front();
        if (out_data.out_char !== want.out_char) begin
          $display("%0t: out_char expected %h got %h", $time,
                   want.out_char, out_data.out_char);
          err_count++;
        end
        if (out_data.run_last !== want.run_last) begin
          $display("%0t: run_last expected %b got %b", $time,
                   want.run_last, out_data.run_last);
          err_count++;
        end
      end
      n = idle_draw();
      out_stall  <= (n != 0);
      stall_left <= n;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= (stall_left > 1);
    end
  end

  // Watchdog on cycles with no beat and no register write
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic void queue_req(logic [1:0] kind, logic [7:0] b);
    bse_pkg::req_t r;
    r.req_type  = kind;
    r.data_byte = b;
    req_fifo.push_back(r);
  endfunction

  task automatic set_reg(logic idx, logic [1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == bse_pkg::CFG_QUOTE_MODE) quote_sel = val;
    else hex_caps = val[0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every request is in and every character is out, then settle
  task automatic drain();
    do @(negedge clk);
    while (req_fifo.size() != 0 || in_valid || escaped_fifo.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Mostly well-formed open/data/close strings, some noise and open runs
  task automatic add_strings(int n);
    int         count;
    int         len;
    logic [7:0] b;
    logic [1:0] kind;
    count = 0;
    while (count < n) begin
      if ($urandom_range(0, 9) == 0) begin
        kind = 2'($urandom_range(0, 3));
        queue_req(kind, 8'($urandom));
        if (kind != REQ_SPARE) count++;
      end else begin
        queue_req(bse_pkg::REQ_OPEN, 8'($urandom));
        len = $urandom_range(0, 6);
        repeat (len) begin
          case ($urandom_range(0, 3))
            0:       b = corner_bytes[4'($urandom_range(0, 13))];
            1:       b = 8'($urandom_range(32'h20, 32'h7E));
            default: b = 8'($urandom);
          endcase
          queue_req(bse_pkg::REQ_DATA, b);
        end
        count += len + 1;
        if ($urandom_range(0, 7) != 0) begin
          queue_req(bse_pkg::REQ_CLOSE, 8'($urandom));
          count++;
        end
      end
    end
  endtask

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset config (no quoting, lower-case hex), corner bytes,
    // data field on open/close, spare request code
    queue_req(bse_pkg::REQ_OPEN, 8'hFF);
    foreach (corner_bytes[i]) queue_req(bse_pkg::REQ_DATA, corner_bytes[i]);
    queue_req(REQ_SPARE, 8'h41);
    queue_req(bse_pkg::REQ_CLOSE, 8'h0A);
    drain();

    // Directed: double quotes, upper-case hex
    set_reg(bse_pkg::CFG_QUOTE_MODE, bse_pkg::QUOTE_DOUBLE);
    set_reg(bse_pkg::CFG_HEX_UPPER, 2'd1);
    queue_req(bse_pkg::REQ_OPEN, 8'h00);
    queue_req(bse_pkg::REQ_DATA, bse_pkg::CH_DQUOTE);
    queue_req(bse_pkg::REQ_DATA, bse_pkg::CH_SQUOTE);
    queue_req(bse_pkg::REQ_DATA, 8'hAB);
    queue_req(bse_pkg::REQ_DATA, bse_pkg::CH_BSLASH);
    queue_req(bse_pkg::REQ_CLOSE, 8'h00);
    drain();

    // Random strings under each setting; one phase runs without idling
    for (int p = 0; p < PHASES; p++) begin
      set_reg(bse_pkg::CFG_QUOTE_MODE, quote_plan[p]);
      set_reg(bse_pkg::CFG_HEX_UPPER, caps_plan[p]);
      steady = (p == 2);
      add_strings(31);
      drain();
    end

    if (err_count == 0 && escaped_fifo.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
